// ----- hw/rtl/necir_pkg.sv -----
package necir_pkg;

   // Decoder status codes as seen on the result channel.
   typedef enum logic [2:0] {
      ST_IDLE         = 3'd0,
      ST_TIMING_ERR   = 3'd1,
      ST_CHECKSUM_ERR = 3'd2,
      ST_PACKET       = 3'd3,
      ST_REPEAT       = 3'd4
   } status_type;

   // Input item kinds.
   localparam logic KIND_EDGE     = 1'b0;
   localparam logic KIND_OVERFLOW = 1'b1;

   // Configuration register indexes.
   localparam int unsigned CSR_INDEX_W = 3;
   localparam logic [CSR_INDEX_W-1:0] CSR_START_WINDOW    = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ONE_WINDOW      = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_ZERO_WINDOW     = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_REPEAT1_WINDOW  = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_REPEAT2_WINDOW  = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_OVERFLOW_LIMIT  = 3'd5;

   // Register reset values.
   localparam logic [31:0] RST_START_WINDOW   = 32'd1900569000;
   localparam logic [31:0] RST_ONE_WINDOW     = 32'd327684000;
   localparam logic [31:0] RST_ZERO_WINDOW    = 32'd176949000;
   localparam logic [31:0] RST_REPEAT1_WINDOW = 32'd1638420000;
   localparam logic [31:0] RST_REPEAT2_WINDOW = 32'd4294961760;
   localparam logic [7:0]  RST_OVERFLOW_LIMIT = 8'd3;

   // Edge counter landmarks.
   localparam logic [5:0] EDGE_START     = 6'd2;
   localparam logic [5:0] EDGE_FIRST_BIT = 6'd3;
   localparam logic [5:0] EDGE_LAST_BIT  = 6'd34;
   localparam logic [5:0] EDGE_CHECK     = 6'd35;
   localparam logic [5:0] EDGE_REPEAT_1  = 6'd36;
   localparam logic [5:0] EDGE_REPEAT_2  = 6'd37;
   localparam logic [5:0] EDGE_MAX       = 6'd63;

   typedef struct packed {
      logic [31:0] start_window;
      logic [31:0] one_window;
      logic [31:0] zero_window;
      logic [31:0] repeat1_window;
      logic [31:0] repeat2_window;
      logic [7:0]  overflow_limit;
   } cfg_type;

   typedef struct packed {
      status_type  status;
      logic        new_packet;
      logic [31:0] frame_bits;
   } result_type;

   // A window packs its minimum in bits 15..0 and its maximum in bits 31..16.
   function automatic logic in_window(input logic [31:0] win, input logic [15:0] iv);
      return (iv >= win[15:0]) && (iv <= win[31:16]);
   endfunction

endpackage

// ----- hw/rtl/necir_cfg_regs.sv -----
module necir_cfg_regs (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_we,
   input  logic [necir_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [31:0]                   csr_wdata,
   output necir_pkg::cfg_type            cfg
);
   import necir_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_START_WINDOW:   cfg_in.start_window   = csr_wdata;
            CSR_ONE_WINDOW:     cfg_in.one_window     = csr_wdata;
            CSR_ZERO_WINDOW:    cfg_in.zero_window    = csr_wdata;
            CSR_REPEAT1_WINDOW: cfg_in.repeat1_window = csr_wdata;
            CSR_REPEAT2_WINDOW: cfg_in.repeat2_window = csr_wdata;
            CSR_OVERFLOW_LIMIT: cfg_in.overflow_limit = csr_wdata[7:0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.start_window   <= RST_START_WINDOW;
         cfg_ff.one_window     <= RST_ONE_WINDOW;
         cfg_ff.zero_window    <= RST_ZERO_WINDOW;
         cfg_ff.repeat1_window <= RST_REPEAT1_WINDOW;
         cfg_ff.repeat2_window <= RST_REPEAT2_WINDOW;
         cfg_ff.overflow_limit <= RST_OVERFLOW_LIMIT;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ----- hw/rtl/necir_decode_core.sv -----
module necir_decode_core (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   step,
   input  logic                   kind,
   input  logic [15:0]            interval,
   input  necir_pkg::cfg_type     cfg,
   output necir_pkg::result_type  result
);
   import necir_pkg::*;

   logic [5:0]  edge_count_ff, edge_count_in;
   status_type  status_ff, status_in;
   logic [31:0] frame_bits_ff, frame_bits_in;
   logic [7:0]  overflow_ff, overflow_in;
   logic [5:0]  edge_inc;
   logic [5:0]  bit_offset;
   logic [4:0]  bit_idx;
   logic [7:0]  overflow_inc;
   logic        pulse;

   always_comb begin
      edge_count_in = edge_count_ff;
      status_in     = status_ff;
      frame_bits_in = frame_bits_ff;
      overflow_in   = overflow_ff;
      pulse         = 1'b0;
      edge_inc      = (edge_count_ff < EDGE_MAX) ? edge_count_ff + 6'd1 : edge_count_ff;
      bit_offset    = edge_inc - EDGE_FIRST_BIT;
      bit_idx       = bit_offset[4:0];
      overflow_inc  = overflow_ff + 8'd1;

      if (kind == KIND_OVERFLOW) begin
         if (overflow_ff < cfg.overflow_limit) begin
            overflow_in = overflow_inc;
            if (overflow_inc == cfg.overflow_limit) begin
               edge_count_in = '0;
               status_in     = ST_IDLE;
            end
         end
      end else begin
         overflow_in   = '0;
         edge_count_in = edge_inc;
         priority if (edge_inc == EDGE_START) begin
            if (!in_window(cfg.start_window, interval)) begin
               edge_count_in = '0;
               status_in     = ST_TIMING_ERR;
            end
         end else if (edge_inc >= EDGE_FIRST_BIT && edge_inc <= EDGE_LAST_BIT) begin
            // The one window is tested first, so it wins where the windows overlap.
            if (in_window(cfg.one_window, interval)) begin
               frame_bits_in[bit_idx] = 1'b1;
            end else if (in_window(cfg.zero_window, interval)) begin
               frame_bits_in[bit_idx] = 1'b0;
            end else begin
               edge_count_in = '0;
               status_in     = ST_TIMING_ERR;
            end
         end else if (edge_inc == EDGE_CHECK) begin
            if (frame_bits_ff[23:16] == ~frame_bits_ff[31:24]) begin
               status_in = ST_PACKET;
               pulse     = 1'b1;
            end else begin
               edge_count_in = '0;
               status_in     = ST_CHECKSUM_ERR;
            end
         end else if (edge_inc == EDGE_REPEAT_1) begin
            if (!in_window(cfg.repeat1_window, interval)) begin
               if (in_window(cfg.start_window, interval)) begin
                  edge_count_in = EDGE_START;
               end else begin
                  edge_count_in = '0;
                  status_in     = ST_TIMING_ERR;
               end
            end
         end else if (edge_inc == EDGE_REPEAT_2) begin
            if (in_window(cfg.repeat2_window, interval)) begin
               edge_count_in = EDGE_CHECK;
               status_in     = ST_REPEAT;
            end else if (in_window(cfg.start_window, interval)) begin
               edge_count_in = EDGE_START;
            end else begin
               edge_count_in = '0;
               status_in     = ST_TIMING_ERR;
            end
         end else begin
            edge_count_in = edge_inc;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         edge_count_ff <= '0;
         status_ff     <= ST_IDLE;
         frame_bits_ff <= '0;
         overflow_ff   <= '0;
      end else if (step) begin
         edge_count_ff <= edge_count_in;
         status_ff     <= status_in;
         frame_bits_ff <= frame_bits_in;
         overflow_ff   <= overflow_in;
      end
   end

   assign result.status     = status_in;
   assign result.new_packet = pulse;
   assign result.frame_bits = frame_bits_in;

   // The counter only ever holds edge numbers of a frame or a repeat code.
   a_edge_range: assert property (@(posedge clock) disable iff (reset)
      edge_count_ff <= EDGE_REPEAT_2)
      else $error("edge counter left the frame range");

   // An accepted edge clears the overflow counter.
   a_edge_clears_ovf: assert property (@(posedge clock) disable iff (reset)
      step && kind == KIND_EDGE |=> overflow_ff == 8'd0)
      else $error("overflow counter not cleared by an edge");

   // A new packet is announced only when the checksum edge lands as received.
   a_pulse_state: assert property (@(posedge clock) disable iff (reset)
      step && pulse |=> status_ff == ST_PACKET && edge_count_ff == EDGE_CHECK)
      else $error("new packet without packet state");

   // Frame bits change only on data-bit edges.
   a_bits_only_on_data: assert property (@(posedge clock) disable iff (reset)
      step && (kind == KIND_OVERFLOW || edge_inc < EDGE_FIRST_BIT
               || edge_inc > EDGE_LAST_BIT) |=> $stable(frame_bits_ff))
      else $error("frame bits changed outside a data edge");

endmodule

// ----- hw/rtl/nec_ir_frame_decoder.sv -----
// Channel  | Direction | Handshake              | Payload
// req      | in        | req_valid / req_ready  | req_kind, req_interval
// rsp      | out       | rsp_valid / rsp_ready  | rsp_status, rsp_new_packet, four data bytes
// csr      | in        | csr_we (no wait)       | csr_index, csr_wdata
//
// Each request transfer is captured in an input register; on advance, the decode logic
// judges it against the current state, updates the state and loads the result register.
// rsp_valid rises when the result register is loaded, so an item passes the input register
// and then the result register; one item per cycle is sustained while rsp_ready is high.
// Reset (synchronous, active high) restores the default windows, clears the decoder state
// and empties both registers. A stalled result holds the input register, which in turn
// drops req_ready only when it is full and cannot advance.
module nec_ir_frame_decoder (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic                              req_kind,
   input  logic [15:0]                       req_interval,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [2:0]                        rsp_status,
   output logic                              rsp_new_packet,
   output logic [7:0]                        rsp_address_low,
   output logic [7:0]                        rsp_address_high,
   output logic [7:0]                        rsp_command,
   output logic [7:0]                        rsp_command_inverse,
   input  logic                              csr_we,
   input  logic [necir_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [31:0]                       csr_wdata
);
   import necir_pkg::*;

   cfg_type     cfg;
   result_type  result;

   // Input register.
   logic        in_valid_ff, in_valid_in;
   logic        in_kind_ff;
   logic [15:0] in_interval_ff;

   // Result register.
   logic        out_valid_ff, out_valid_in;
   result_type  out_ff;

   logic        req_xfer;
   logic        advance;

   // The held item moves into the result register when that register is free or
   // its contents are transferred in the same cycle.
   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign req_xfer  = req_valid && req_ready;

   assign in_valid_in  = req_xfer || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && !rsp_ready);

   necir_cfg_regs u_cfg (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   necir_decode_core u_core (
      .clock    (clock),
      .reset    (reset),
      .step     (advance),
      .kind     (in_kind_ff),
      .interval (in_interval_ff),
      .cfg      (cfg),
      .result   (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers carry no reset; their valid flags qualify them.
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         in_kind_ff     <= req_kind;
         in_interval_ff <= req_interval;
      end
      if (advance) begin
         out_ff <= result;
      end
   end

   assign rsp_valid           = out_valid_ff;
   assign rsp_status          = out_ff.status;
   assign rsp_new_packet      = out_ff.new_packet;
   assign rsp_address_low     = out_ff.frame_bits[7:0];
   assign rsp_address_high    = out_ff.frame_bits[15:8];
   assign rsp_command         = out_ff.frame_bits[23:16];
   assign rsp_command_inverse = out_ff.frame_bits[31:24];

   // The held item may only advance when the result register can take it.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !rsp_ready |-> !advance)
      else $error("result register overwritten while stalled");

   // A waiting result stays unchanged until it is transferred.
   a_result_held: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !rsp_ready |=> out_valid_ff && $stable(out_ff))
      else $error("stalled result changed");

   // A full input register that cannot advance must refuse new requests.
   a_input_blocked: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |-> !req_ready)
      else $error("input register overrun");

endmodule
